>>> hw/rtl/jpeg_marker_stream_checker_assert.svh
// assertion macros for the jpeg marker stream checker
`ifndef JPEG_MARKER_STREAM_CHECKER_ASSERT_SVH
`define JPEG_MARKER_STREAM_CHECKER_ASSERT_SVH

// same-cycle implication
`define JMSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jmsc assertion failed");

// next-cycle implication
`define JMSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jmsc assertion failed");

`endif

>>> hw/rtl/jmsc_pkg.sv
// shared types and constants for the jpeg marker stream checker
package jmsc_pkg;

    localparam logic [7:0] MARK_PREFIX = 8'hff;
    localparam logic [7:0] MARK_SOI    = 8'hd8;
    localparam logic [7:0] MARK_EOI    = 8'hd9;
    localparam logic [7:0] MARK_SOS    = 8'hda;
    localparam logic [7:0] MARK_RST_LO = 8'hd0;
    localparam logic [7:0] MARK_RST_HI = 8'hd7;
    localparam logic [7:0] MARK_STUFF  = 8'h00;

    localparam logic [3:0] MIN_FILE_BYTES = 4'd8;
    localparam logic [2:0] MARKER_SPAN    = 3'd4;

    typedef enum logic [3:0] {
        STAT_OK             = 4'd0,
        STAT_BAD_START      = 4'd1,
        STAT_BAD_MARKER     = 4'd2,
        STAT_MARKER_CUT     = 4'd3,
        STAT_EARLY_END      = 4'd4,
        STAT_SEGMENT_CUT    = 4'd5,
        STAT_BAD_LENGTH     = 4'd6,
        STAT_NO_SCAN        = 4'd7,
        STAT_ENT_MARKER_CUT = 4'd8,
        STAT_BAD_ENT_MARKER = 4'd9,
        STAT_INCOMPLETE     = 4'd10
    } t_status;

    typedef enum logic [9:0] {
        PH_SOI0   = 10'b0000000001,
        PH_SOI1   = 10'b0000000010,
        PH_MSTART = 10'b0000000100,
        PH_FILL   = 10'b0000001000,
        PH_LENHI  = 10'b0000010000,
        PH_LENLO  = 10'b0000100000,
        PH_SKIP   = 10'b0001000000,
        PH_ENT    = 10'b0010000000,
        PH_EFF    = 10'b0100000000,
        PH_ERR    = 10'b1000000000
    } t_phase;

    typedef struct packed {
        logic    valid;
        t_status code;
    } t_verdict;

    function automatic logic is_rst(input logic [7:0] b);
        return (b >= MARK_RST_LO) && (b <= MARK_RST_HI);
    endfunction

endpackage

>>> hw/rtl/jmsc_parser.sv
// marker structure state machine and verdict logic, one byte per step
module jmsc_parser import jmsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_eof,
    output t_verdict   o_verdict
);

    t_phase      r_phase,   n_phase;
    logic [7:0]  r_len_hi,  n_len_hi;
    logic [15:0] r_skip,    n_skip;
    t_status     r_err,     n_err;
    logic        r_ent,     n_ent;
    logic [3:0]  r_cnt,     n_cnt;
    logic [7:0]  r_marker,  n_marker;
    logic [2:0]  r_off,     n_off;

    logic        do_fail;
    t_status     fail_code;
    logic        seg_end;
    logic        eoi_ok;
    logic [15:0] seg_len;
    logic [15:0] skip_left;
    t_status     code;

    assign seg_len   = {r_len_hi, i_byte};
    assign skip_left = r_skip - 16'd1;

    always_comb begin
        n_phase   = r_phase;
        n_len_hi  = r_len_hi;
        n_skip    = r_skip;
        n_ent     = r_ent;
        n_marker  = r_marker;
        n_cnt     = (r_cnt < MIN_FILE_BYTES) ? r_cnt + 4'd1 : r_cnt;
        n_off     = (r_off < MARKER_SPAN) ? r_off + 3'd1 : r_off;
        do_fail   = 1'b0;
        fail_code = STAT_OK;
        seg_end   = 1'b0;
        eoi_ok    = 1'b0;
        case (r_phase)
            PH_SOI0: begin
                if (i_byte == MARK_PREFIX) begin
                    n_phase = PH_SOI1;
                end else begin
                    do_fail = 1'b1; fail_code = STAT_BAD_START;
                end
            end
            PH_SOI1: begin
                if (i_byte == MARK_SOI) begin
                    n_phase = PH_MSTART;
                    n_off   = 3'd0;
                end else begin
                    do_fail = 1'b1; fail_code = STAT_BAD_START;
                end
            end
            PH_MSTART: begin
                if (i_byte == MARK_PREFIX) begin
                    n_phase = PH_FILL;
                end else begin
                    do_fail = 1'b1; fail_code = STAT_BAD_MARKER;
                end
            end
            PH_FILL: begin
                if (i_byte == MARK_PREFIX) begin
                    n_phase = PH_FILL;
                end else if (i_byte == MARK_EOI || i_byte == MARK_STUFF || is_rst(i_byte)) begin
                    do_fail = 1'b1; fail_code = STAT_EARLY_END;
                end else begin
                    n_marker = i_byte;
                    n_phase  = PH_LENHI;
                end
            end
            PH_LENHI: begin
                n_len_hi = i_byte;
                n_phase  = PH_LENLO;
            end
            PH_LENLO: begin
                if (seg_len < 16'd2) begin
                    do_fail = 1'b1; fail_code = STAT_BAD_LENGTH;
                end else begin
                    n_skip = seg_len - 16'd2;
                    if (seg_len == 16'd2) begin
                        seg_end = 1'b1;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_skip = skip_left;
                if (skip_left == 16'd0) begin
                    seg_end = 1'b1;
                end
            end
            PH_ENT: begin
                if (i_byte == MARK_PREFIX) begin
                    n_phase = PH_EFF;
                end else begin
                    n_ent = 1'b1;
                end
            end
            PH_EFF: begin
                if (i_byte == MARK_PREFIX) begin
                    n_phase = PH_EFF;
                end else if (i_byte == MARK_STUFF || is_rst(i_byte)) begin
                    n_phase = PH_ENT;
                end else if (i_byte == MARK_EOI && i_eof && r_ent) begin
                    eoi_ok = 1'b1;
                end else begin
                    do_fail = 1'b1; fail_code = STAT_BAD_ENT_MARKER;
                end
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase

        // end of segment: scan data after sos, otherwise the next marker
        if (seg_end) begin
            if (r_marker == MARK_SOS) begin
                n_phase = PH_ENT;
            end else begin
                n_phase = PH_MSTART;
                n_off   = 3'd0;
            end
        end

        n_err = r_err;
        if (do_fail) begin
            n_phase = PH_ERR;
            if (r_err == STAT_OK) begin
                n_err = fail_code;
            end
        end
    end

    always_comb begin
        if (n_cnt < MIN_FILE_BYTES) begin
            code = STAT_BAD_START;
        end else if (n_off < MARKER_SPAN) begin
            code = STAT_NO_SCAN;
        end else if (n_err != STAT_OK) begin
            code = n_err;
        end else if (eoi_ok) begin
            code = STAT_OK;
        end else if (seg_end) begin
            code = STAT_NO_SCAN;
        end else begin
            case (n_phase)
                PH_FILL:  code = STAT_MARKER_CUT;
                PH_LENHI: code = STAT_SEGMENT_CUT;
                PH_LENLO: code = STAT_SEGMENT_CUT;
                PH_SKIP:  code = STAT_BAD_LENGTH;
                PH_ENT:   code = STAT_INCOMPLETE;
                PH_EFF:   code = STAT_ENT_MARKER_CUT;
                default:  code = STAT_NO_SCAN;
            endcase
        end
    end

    assign o_verdict = '{valid: i_step && i_eof, code: code};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_eof)) begin
            r_phase  <= PH_SOI0;
            r_len_hi <= 8'd0;
            r_skip   <= 16'd0;
            r_err    <= STAT_OK;
            r_ent    <= 1'b0;
            r_cnt    <= 4'd0;
            r_marker <= 8'd0;
            r_off    <= MARKER_SPAN;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_len_hi <= n_len_hi;
            r_skip   <= n_skip;
            r_err    <= n_err;
            r_ent    <= n_ent;
            r_cnt    <= n_cnt;
            r_marker <= n_marker;
            r_off    <= n_off;
        end
    end

endmodule

>>> hw/rtl/jpeg_marker_stream_checker.sv
// top level of the jpeg marker stream checker
//
// input channel: one file byte per transaction on i_data_byte, with
// i_end_of_file high on the final byte; i_valid / o_stall handshake.
// output channel: one verdict per file on o_status_code and o_stream_ok,
// o_valid / i_stall handshake; no transaction for bytes that do not end a file.
// a byte is held in the input register and checked on the way to the parser
// state; a verdict is registered in the output register as its final byte
// leaves the input register.
// throughput: one byte per cycle while o_stall is low.
// a full result register held by i_stall only blocks the next final byte;
// ordinary bytes keep flowing, and o_stall rises only when a final byte waits
// behind an undelivered verdict.
// reset (synchronous, active low) empties both registers and returns the parser
// to the start of a file; after each verdict the parser starts a new file too.
module jpeg_marker_stream_checker import jmsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_file,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_status_code,
    output logic       o_stream_ok
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eof;
    logic       r_out_valid;
    t_status    r_out_code;
    logic       advance;
    logic       accept;
    t_verdict   verdict;

    assign advance = r_in_valid && (!r_in_eof || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    jmsc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_byte    (r_in_byte),
        .i_eof     (r_in_eof),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (verdict.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (verdict.valid) begin
            r_out_code <= verdict.code;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status_code = r_out_code;
    assign o_stream_ok   = (r_out_code == STAT_OK);

endmodule

>>> hw/rtl/jmsc_checker.sv
// port-level assertions for the jpeg marker stream checker, with its bind
`include "jpeg_marker_stream_checker_assert.svh"

module jmsc_checker import jmsc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_status_code,
    input logic       o_stream_ok
);

    `JMSC_ASSERT_IMPL(a_ok_matches_code, o_valid, o_stream_ok == (o_status_code == STAT_OK))
    `JMSC_ASSERT_IMPL(a_code_in_range, o_valid, o_status_code <= STAT_INCOMPLETE)
    `JMSC_ASSERT_IMPL(a_stall_only_behind_verdict, o_stall, o_valid && i_stall)
    `JMSC_ASSERT_NEXT(a_held_verdict, o_valid && i_stall, o_valid && $stable(o_status_code))

endmodule

bind jpeg_marker_stream_checker jmsc_checker u_jmsc_checker (.*);
